FILE: design/escaped_frame_decoder_crc16_top_macros.svh
// Assertion macros shared by the decoder's checker.
`ifndef ESCAPED_FRAME_DECODER_CRC16_TOP_MACROS_SVH
`define ESCAPED_FRAME_DECODER_CRC16_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define EFD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define EFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/efd_pkg.sv
// Shared types, codes and the CRC-16 step of the escaped frame decoder.
package efd_pkg;

   localparam logic [7:0] FLAG_START = 8'h5B;
   localparam logic [7:0] FLAG_END   = 8'h5D;
   localparam logic [7:0] MARK_ESC   = 8'h5C;
   localparam logic [7:0] ESC_FLIP   = 8'h20;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_GOOD     = 3'd1;
   localparam logic [2:0] KIND_CRCERR   = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
   localparam logic [2:0] KIND_ABORT    = 3'd5;

   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] REG_BUFFER_SIZE   = 2'd1;
   localparam logic [1:0] REG_CRC_SEED      = 2'd2;
   localparam logic [1:0] REG_CRC_FINAL_XOR = 2'd3;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;
   localparam logic [15:0] BUFFER_SIZE_RESET   = 16'd256;
   localparam logic [15:0] CRC_SEED_RESET      = 16'hFFFF;
   localparam logic [15:0] CRC_FINAL_XOR_RESET = 16'h0000;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CLS_TICK,
      CLS_START,
      CLS_END,
      CLS_ESC,
      CLS_DATA
   } efd_class_type;

   typedef struct packed {
      efd_class_type cls;
      logic [7:0]    data;
   } efd_cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] frame_length;
      logic        last;
   } efd_rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] buffer_size;
      logic [15:0] crc_seed;
      logic [15:0] crc_final_xor;
   } efd_cfg_type;

   // One byte through CRC-16, MSB first, no reflection.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: design/efd_fifo.sv
// Small register queue used between the decoder's stages.
module efd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/efd_front.sv
// Front end: sorts each incoming item into tick, flag, escape or data.
module efd_front (
   input  logic                  action,
   input  logic [7:0]            rx_byte,
   output efd_pkg::efd_cmd_type  cmd
);

   always_comb begin
      cmd.data = rx_byte;
      if (action) begin
         cmd.cls = efd_pkg::CLS_TICK;
      end else begin
         case (rx_byte)
            efd_pkg::FLAG_START: cmd.cls = efd_pkg::CLS_START;
            efd_pkg::FLAG_END:   cmd.cls = efd_pkg::CLS_END;
            efd_pkg::MARK_ESC:   cmd.cls = efd_pkg::CLS_ESC;
            default:             cmd.cls = efd_pkg::CLS_DATA;
         endcase
      end
   end

endmodule

FILE: design/efd_csr.sv
// Configuration registers behind the APB-style port.
module efd_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output efd_pkg::efd_cfg_type cfg
);

   logic [15:0] timeout_ticks_ff;
   logic [15:0] buffer_size_ff;
   logic [15:0] crc_seed_ff;
   logic [15:0] crc_final_xor_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= efd_pkg::TIMEOUT_TICKS_RESET;
         buffer_size_ff   <= efd_pkg::BUFFER_SIZE_RESET;
         crc_seed_ff      <= efd_pkg::CRC_SEED_RESET;
         crc_final_xor_ff <= efd_pkg::CRC_FINAL_XOR_RESET;
      end else if (wr_en) begin
         case (paddr[3:2])
            efd_pkg::REG_TIMEOUT_TICKS: timeout_ticks_ff <= pwdata[15:0];
            efd_pkg::REG_BUFFER_SIZE:   buffer_size_ff   <= pwdata[15:0];
            efd_pkg::REG_CRC_SEED:      crc_seed_ff      <= pwdata[15:0];
            efd_pkg::REG_CRC_FINAL_XOR: crc_final_xor_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         efd_pkg::REG_TIMEOUT_TICKS: prdata = {16'h0000, timeout_ticks_ff};
         efd_pkg::REG_BUFFER_SIZE:   prdata = {16'h0000, buffer_size_ff};
         efd_pkg::REG_CRC_SEED:      prdata = {16'h0000, crc_seed_ff};
         efd_pkg::REG_CRC_FINAL_XOR: prdata = {16'h0000, crc_final_xor_ff};
         default:                    prdata = '0;
      endcase
   end

   assign cfg.timeout_ticks = timeout_ticks_ff;
   assign cfg.buffer_size   = buffer_size_ff;
   assign cfg.crc_seed      = crc_seed_ff;
   assign cfg.crc_final_xor = crc_final_xor_ff;

endmodule

FILE: design/efd_back.sv
// Back end: framing state, CRC tracking and result generation.
module efd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  efd_pkg::efd_cfg_type cfg,
   input  efd_pkg::efd_cmd_type cmd,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output efd_pkg::efd_rsp_type rsp
);

   logic        in_frame_ff, in_frame_in;
   logic        after_escape_ff, after_escape_in;
   logic [7:0]  held_older_ff, held_older_in;
   logic [7:0]  held_newer_ff, held_newer_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [15:0] content_count_ff, content_count_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;

   logic        take;
   logic        do_clear;
   logic        do_open;
   logic [7:0]  content;
   logic [15:0] expected;
   logic [15:0] actual;

   // An item is worked off only when the result queue has room, whether or not it gives a result.
   assign take    = !cmd_empty && !rsp_full;
   assign cmd_pop = take;

   always_comb begin
      in_frame_in      = in_frame_ff;
      after_escape_in  = after_escape_ff;
      held_older_in    = held_older_ff;
      held_newer_in    = held_newer_ff;
      held_count_in    = held_count_ff;
      content_count_in = content_count_ff;
      running_crc_in   = running_crc_ff;
      idle_ticks_in    = idle_ticks_ff;
      do_clear         = 1'b0;
      do_open          = 1'b0;
      rsp_push         = 1'b0;
      rsp              = '0;
      content          = after_escape_ff ? (cmd.data ^ efd_pkg::ESC_FLIP) : cmd.data;
      expected         = {held_newer_ff, held_older_ff};
      actual           = running_crc_ff ^ cfg.crc_final_xor;

      if (take) begin
         if (cmd.cls != efd_pkg::CLS_TICK) begin
            idle_ticks_in = '0;
         end
         case (cmd.cls)
            efd_pkg::CLS_TICK: begin
               if (idle_ticks_ff >= cfg.timeout_ticks) begin
                  do_clear = 1'b1;
                  rsp_push = 1'b1;
                  rsp.kind = efd_pkg::KIND_TIMEOUT;
                  rsp.last = 1'b1;
               end else begin
                  idle_ticks_in = idle_ticks_ff + 16'd1;
               end
            end
            efd_pkg::CLS_START: begin
               do_open = 1'b1;
               if (in_frame_ff) begin
                  do_clear = 1'b1;
                  rsp_push = 1'b1;
                  rsp.kind = efd_pkg::KIND_ABORT;
                  rsp.last = 1'b1;
               end
            end
            efd_pkg::CLS_END: begin
               if (in_frame_ff) begin
                  do_clear = 1'b1;
                  rsp_push = 1'b1;
                  rsp.last = 1'b1;
                  if (content_count_ff >= 16'd2 && expected == actual) begin
                     rsp.kind         = efd_pkg::KIND_GOOD;
                     rsp.frame_length = content_count_ff - 16'd2;
                  end else begin
                     rsp.kind = efd_pkg::KIND_CRCERR;
                  end
               end
            end
            efd_pkg::CLS_ESC: begin
               after_escape_in = 1'b1;
            end
            efd_pkg::CLS_DATA: begin
               if (in_frame_ff) begin
                  after_escape_in = 1'b0;
                  if (content_count_ff >= cfg.buffer_size) begin
                     do_clear = 1'b1;
                     rsp_push = 1'b1;
                     rsp.kind = efd_pkg::KIND_OVERFLOW;
                     rsp.last = 1'b1;
                  end else begin
                     content_count_in = content_count_ff + 16'd1;
                     held_older_in    = held_newer_ff;
                     held_newer_in    = content;
                     if (held_count_ff == 2'd2) begin
                        running_crc_in   = efd_pkg::crc16_byte(running_crc_ff, held_older_ff);
                        rsp_push         = 1'b1;
                        rsp.kind         = efd_pkg::KIND_PAYLOAD;
                        rsp.payload_byte = held_older_ff;
                     end else begin
                        held_count_in = held_count_ff + 2'd1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // A status ends the attempt; a start flag then opens a fresh frame.
      if (do_clear) begin
         in_frame_in      = 1'b0;
         after_escape_in  = 1'b0;
         held_count_in    = '0;
         content_count_in = '0;
         running_crc_in   = cfg.crc_seed;
         idle_ticks_in    = '0;
      end
      if (do_open) begin
         in_frame_in      = 1'b1;
         held_count_in    = '0;
         content_count_in = '0;
         running_crc_in   = cfg.crc_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff      <= 1'b0;
         after_escape_ff  <= 1'b0;
         held_count_ff    <= '0;
         content_count_ff <= '0;
         running_crc_ff   <= efd_pkg::CRC_SEED_RESET;
         idle_ticks_ff    <= '0;
      end else begin
         in_frame_ff      <= in_frame_in;
         after_escape_ff  <= after_escape_in;
         held_count_ff    <= held_count_in;
         content_count_ff <= content_count_in;
         running_crc_ff   <= running_crc_in;
         idle_ticks_ff    <= idle_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      held_older_ff <= held_older_in;
      held_newer_ff <= held_newer_in;
   end

endmodule

FILE: design/escaped_frame_decoder_crc16_top.sv
// Top level of the byte-stuffed frame decoder with CRC-16 check.
// The input channel is a queue write port: each transfer carries either a received
// line byte (req_action low) or one time tick (req_action high), and it is taken at a
// clock edge with push high and full low. Results leave through a queue read port:
// the oldest result sits on the rsp_ ports while empty is low, and a transfer occurs
// at an edge with pop high and empty low. Each item gives zero or one result.
// A front stage classifies every accepted item and writes it into a command queue.
// The back stage takes one command per cycle while the result queue has room,
// updates the framing state and the CRC, and writes any result into a result
// queue. The block sustains one item per cycle while the receiver keeps up; a
// result passes through the command queue write and then the result queue write
// before it is on the rsp_ ports.
// When the receiver stalls, the result queue fills, the back stage pauses, and the
// command queue absorbs further items until full rises; nothing is dropped.
// Reset is synchronous: both queues empty, framing state clears, configuration
// registers reset. The user must write configuration through the APB-style port
// only while the block is idle; the block does not enforce it. pready is always high.
module escaped_frame_decoder_crc16_top #(
   parameter int CMD_DEPTH = efd_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = efd_pkg::RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CMD_W = $bits(efd_pkg::efd_cmd_type);
   localparam int RSP_W = $bits(efd_pkg::efd_rsp_type);

   efd_pkg::efd_cfg_type cfg;
   efd_pkg::efd_cmd_type front_cmd;
   efd_pkg::efd_cmd_type back_cmd;
   efd_pkg::efd_rsp_type back_rsp;
   efd_pkg::efd_rsp_type out_rsp;
   logic [CMD_W-1:0]     cmd_bits;
   logic [RSP_W-1:0]     rsp_bits;
   logic                 cmd_empty;
   logic                 cmd_pop;
   logic                 rsp_full;
   logic                 rsp_push;

   efd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   efd_front u_front (
      .action  (req_action),
      .rx_byte (req_rx_byte),
      .cmd     (front_cmd)
   );

   // Command queue: decouples line input from the framing engine.
   efd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_cmd),
      .full    (full),
      .pop     (cmd_pop),
      .rd_data (cmd_bits),
      .empty   (cmd_empty)
   );

   assign back_cmd = efd_pkg::efd_cmd_type'(cmd_bits);

   efd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   // Result queue: holds finished results while the receiver stalls.
   efd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_bits),
      .empty   (empty)
   );

   assign out_rsp          = efd_pkg::efd_rsp_type'(rsp_bits);
   assign rsp_kind         = out_rsp.kind;
   assign rsp_payload_byte = out_rsp.payload_byte;
   assign rsp_frame_length = out_rsp.frame_length;
   assign rsp_last         = out_rsp.last;

endmodule

FILE: design/efd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
`include "escaped_frame_decoder_crc16_top_macros.svh"

module efd_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [15:0] rsp_frame_length,
   input logic        rsp_last
);

   `EFD_ASSERT_IMPL(a_last_marks_status, clock, reset, !empty, rsp_last == (rsp_kind != efd_pkg::KIND_PAYLOAD), "last flag disagrees with result kind")

   `EFD_ASSERT_IMPL(a_length_only_good, clock, reset, !empty && (rsp_kind != efd_pkg::KIND_GOOD), rsp_frame_length == 16'd0, "frame length set on a result that is not a good frame")

   `EFD_ASSERT_IMPL(a_byte_only_payload, clock, reset, !empty && (rsp_kind != efd_pkg::KIND_PAYLOAD), rsp_payload_byte == 8'd0, "payload byte set on a status result")

   `EFD_ASSERT_NEXT(a_stalled_result_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_kind) && $stable(rsp_payload_byte) && $stable(rsp_frame_length), "waiting result changed before its transfer")

endmodule

bind escaped_frame_decoder_crc16_top efd_checker u_efd_checker (.*);
